// ===== hw/rtl/bwg_pkg.sv =====
// Shared constants, types and the quarter-sine table builder for the waveform generator.
package bwg_pkg;

   localparam int unsigned FRAME_BITS  = 32;
   localparam int unsigned SAMPLE_BITS = 16;
   localparam int unsigned RATE_BITS   = 18;
   localparam int unsigned SHAPE_BITS  = 3;
   localparam int unsigned CSR_INDEX_BITS = 1;

   localparam int unsigned DEFAULT_SINE_TABLE_DEPTH = 1024;
   localparam int unsigned DEFAULT_PHASE_BITS       = 24;

   // Middle C in Q16, and the divisor is sample_rate in Q16
   localparam int unsigned BASE_FREQ_BITS      = 25;
   localparam int unsigned BASE_FREQ_FRAC_BITS = 16;
   localparam logic [BASE_FREQ_BITS-1:0] BASE_FREQ_Q16 = 25'd17145893;
   localparam int unsigned DIVISOR_BITS = RATE_BITS + BASE_FREQ_FRAC_BITS;

   localparam logic [RATE_BITS-1:0]  RATE_RESET  = 18'd44100;
   localparam logic [SHAPE_BITS-1:0] SHAPE_RESET = 3'd0;

   localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
   localparam logic [31:0] LFSR_SEED = 32'h0000_ACE1;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210};

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLE_RATE = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAVE_SHAPE  = 1'd1;

   localparam logic [SHAPE_BITS-1:0] SHAPE_SINE     = 3'd0;
   localparam logic [SHAPE_BITS-1:0] SHAPE_SAW      = 3'd1;
   localparam logic [SHAPE_BITS-1:0] SHAPE_SQUARE   = 3'd2;
   localparam logic [SHAPE_BITS-1:0] SHAPE_TRIANGLE = 3'd3;
   localparam logic [SHAPE_BITS-1:0] SHAPE_NOISE    = 3'd4;

   typedef enum logic [5:0] {
      PH_IDLE = 6'b000001,
      PH_FMOD = 6'b000010,
      PH_MDBL = 6'b000100,
      PH_MADD = 6'b001000,
      PH_NEG  = 6'b010000,
      PH_DIV  = 6'b100000
   } phase_state_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PHASE = 4'b0010,
      ST_LOOK  = 4'b0100,
      ST_WRITE = 4'b1000
   } ctrl_state_type;

   // Quarter sine entry in Q15 from a Taylor series in Q30; elaboration only
   function automatic logic [15:0] qsin_entry(input int unsigned idx,
                                              input int unsigned depth_log2);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] acc;
      x    = (HALF_PI_Q30 * 64'(idx)) >> depth_log2;
      x2   = (x * x) >> 30;
      term = x;
      acc  = signed'(x);
      for (int k = 1; k <= 7; k++) begin
         term = (term * x2) / TAYLOR_DIV[k-1];
         if (k[0]) begin
            acc = acc - signed'(term);
         end else begin
            acc = acc + signed'(term);
         end
      end
      if (acc < 0) begin
         acc = 64'sd0;
      end
      acc = (acc + 64'sd16384) >>> 15;
      if (acc > 64'sd32767) begin
         acc = 64'sd32767;
      end
      return acc[15:0];
   endfunction

endpackage

// ===== hw/rtl/basic_waveform_generator_core.sv =====
// Top level of the waveform generator: handshakes, shape select, noise LFSR, output register.
//
//  channel | ports                                         | dir
//  --------+-----------------------------------------------+-----
//  req     | req_valid, req_ready, req_frame_index[31:0]   | in
//  rsp     | rsp_valid, rsp_ready, rsp_sample_value[15:0]  | out
//  csr     | csr_valid, csr_ready, csr_index, csr_data     | in
//
// An item goes from transfer to result as follows: the phase unit reduces f0 mod d one
// bit a cycle, runs the modular multiply as a double step and an add step per frame bit,
// then the sign fix and the divide, one quotient bit a cycle; done is seen while the ROM
// reads, then a lookup state and the load; the next transfer can be taken in the cycle after the load.
// Reset is synchronous; it restores the registers, seeds the LFSR, empties the output.
// A stalled result waits in the output register while the next item is taken.
module basic_waveform_generator_core #(
   parameter int unsigned SINE_TABLE_DEPTH = bwg_pkg::DEFAULT_SINE_TABLE_DEPTH,
   parameter int unsigned PHASE_BITS       = bwg_pkg::DEFAULT_PHASE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [bwg_pkg::FRAME_BITS-1:0] req_frame_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [bwg_pkg::SAMPLE_BITS-1:0] rsp_sample_value,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bwg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bwg_pkg::RATE_BITS-1:0]       csr_data
);
   import bwg_pkg::*;

   localparam int unsigned SINE_ADDR_BITS = $clog2(SINE_TABLE_DEPTH);

   ctrl_state_type         state_ff, state_in;
   logic [RATE_BITS-1:0]   rate_ff;
   logic [SHAPE_BITS-1:0]  shape_ff;
   logic [31:0]            lfsr_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] sample_ff;

   logic                      start;
   logic                      phase_done;
   logic [31:0]               t;
   logic [1:0]                quad;
   logic [SINE_ADDR_BITS-1:0] idx;
   logic [SINE_ADDR_BITS-1:0] rom_addr;
   logic [15:0]               rom_data;
   logic [15:0]               sine_mag;
   logic [15:0]               sine_val;
   logic [16:0]               tri_fall;
   logic [15:0]               tri_val;
   logic [31:0]               lfsr_step;
   logic [SAMPLE_BITS-1:0]    sample;
   logic                      load;

   assign req_ready = (state_ff == ST_IDLE);
   assign start     = req_valid && req_ready;
   assign csr_ready = 1'b1;

   bwg_phase #(
      .PHASE_BITS (PHASE_BITS)
   ) u_phase (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .frame       (req_frame_index),
      .sample_rate (rate_ff),
      .done        (phase_done),
      .phase       (t)
   );

   // Sine: odd quadrants read the table mirrored
   assign quad     = t[31:30];
   assign idx      = t[29 -: SINE_ADDR_BITS];
   assign rom_addr = quad[0] ? (~idx + SINE_ADDR_BITS'(1)) : idx;

   bwg_sine_rom #(
      .DEPTH     (SINE_TABLE_DEPTH),
      .ADDR_BITS (SINE_ADDR_BITS)
   ) u_sine_rom (
      .clock (clock),
      .addr  (rom_addr),
      .data  (rom_data)
   );

   assign sine_mag = (quad[0] && (idx == '0)) ? 16'd32767 : rom_data;
   assign sine_val = quad[1] ? (~sine_mag + 16'd1) : sine_mag;

   // Falling half of the triangle; +1.0 saturates
   assign tri_fall = 17'h0_8000 - {1'b0, t[30:15]};
   assign tri_val  = !t[31] ? {~t[30], t[29:15]}
                   : (t[30:15] == '0) ? 16'h7FFF : tri_fall[15:0];

   assign lfsr_step = {1'b0, lfsr_ff[31:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : 32'h0);

   always_comb begin
      case (shape_ff)
         SHAPE_SINE:     sample = sine_val;
         SHAPE_SAW:      sample = {~t[31], t[30:16]};
         SHAPE_SQUARE:   sample = (t[31] && (t[30:0] != '0)) ? 16'h7FFF : 16'h8000;
         SHAPE_TRIANGLE: sample = tri_val;
         SHAPE_NOISE:    sample = lfsr_step[31:16];
         default:        sample = '0;
      endcase
   end

   assign load = (state_ff == ST_WRITE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start) state_in = ST_PHASE;
         ST_PHASE: if (phase_done) state_in = ST_LOOK;
         ST_LOOK:  state_in = ST_WRITE;
         ST_WRITE: if (load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rate_ff      <= RATE_RESET;
         shape_ff     <= SHAPE_RESET;
         lfsr_ff      <= LFSR_SEED;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SAMPLE_RATE: rate_ff  <= csr_data;
               CSR_WAVE_SHAPE:  shape_ff <= csr_data[SHAPE_BITS-1:0];
               default:         rate_ff  <= rate_ff;
            endcase
         end
         // advance the LFSR only on a noise transfer
         if (load && (shape_ff == SHAPE_NOISE)) begin
            lfsr_ff <= lfsr_step;
         end
      end
      if (load) begin
         sample_ff <= sample;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = signed'(sample_ff);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> (state_ff == ST_PHASE))
      else $error("accepted item did not start the phase unit");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      phase_done |-> (state_ff == ST_PHASE))
      else $error("phase done outside of phase wait");

   a_lfsr_live: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != 32'h0)
      else $error("noise LFSR locked at zero");

endmodule

// ===== hw/rtl/bwg_sine_rom.sv =====
// Quarter-wave sine ROM with registered read.
module bwg_sine_rom #(
   parameter int unsigned DEPTH     = bwg_pkg::DEFAULT_SINE_TABLE_DEPTH,
   parameter int unsigned ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic [ADDR_BITS-1:0] addr,
   output logic [15:0]          data
);
   import bwg_pkg::*;

   typedef logic [15:0] rom_type [DEPTH];

   function automatic rom_type build_rom();
      rom_type rom;
      for (int i = 0; i < int'(DEPTH); i++) begin
         rom[i] = qsin_entry(i, ADDR_BITS);
      end
      return rom;
   endfunction

   localparam rom_type SineRom = build_rom();

   logic [15:0] data_ff;

   always_ff @(posedge clock) begin
      data_ff <= SineRom[addr];
   end

   assign data = data_ff;

endmodule

// ===== hw/rtl/bwg_phase.sv =====
// Bit-serial phase unit: (frame * f0) mod (rate << 16), then a restoring divide to a fraction.
module bwg_phase #(
   parameter int unsigned PHASE_BITS = bwg_pkg::DEFAULT_PHASE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bwg_pkg::FRAME_BITS-1:0] frame,
   input  logic [bwg_pkg::RATE_BITS-1:0]  sample_rate,
   output logic                          done,
   output logic [31:0]                   phase
);
   import bwg_pkg::*;

   localparam int unsigned CNT_BITS = $clog2(FRAME_BITS);

   phase_state_type         state_ff, state_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [DIVISOR_BITS-1:0] r_ff, r_in;
   logic [DIVISOR_BITS-1:0] fm_ff, fm_in;
   logic [DIVISOR_BITS-1:0] d_ff, d_in;
   logic [FRAME_BITS-1:0]   mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic [PHASE_BITS-1:0]   q_ff, q_in;
   logic                    done_ff, done_in;

   logic [DIVISOR_BITS:0]   a_op;
   logic [DIVISOR_BITS-1:0] b_op;
   logic [DIVISOR_BITS:0]   sum;
   logic [DIVISOR_BITS:0]   diff;
   logic                    fits;
   logic [DIVISOR_BITS-1:0] res;
   logic [RATE_BITS-1:0]    rate_eff;

   assign rate_eff = (sample_rate == '0) ? RATE_BITS'(1) : sample_rate;

   // Shared add / compare-subtract: keeps r below d
   always_comb begin
      a_op = '0;
      b_op = '0;
      case (state_ff)
         PH_FMOD: a_op = {r_ff, BASE_FREQ_Q16[cnt_ff]};
         PH_MDBL: a_op = {r_ff, 1'b0};
         PH_DIV:  a_op = {r_ff, 1'b0};
         PH_MADD: begin
            a_op = {1'b0, r_ff};
            b_op = mag_ff[FRAME_BITS-1] ? fm_ff : '0;
         end
         default: a_op = '0;
      endcase
   end

   assign sum  = a_op + {1'b0, b_op};
   assign diff = sum - {1'b0, d_ff};
   assign fits = (sum >= {1'b0, d_ff});
   assign res  = fits ? diff[DIVISOR_BITS-1:0] : sum[DIVISOR_BITS-1:0];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      r_in     = r_ff;
      fm_in    = fm_ff;
      d_in     = d_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      q_in     = q_ff;
      done_in  = 1'b0;
      case (state_ff)
         PH_IDLE: begin
            if (start) begin
               d_in     = {rate_eff, BASE_FREQ_FRAC_BITS'(0)};
               neg_in   = frame[FRAME_BITS-1];
               mag_in   = frame[FRAME_BITS-1] ? (~frame + FRAME_BITS'(1)) : frame;
               r_in     = '0;
               cnt_in   = CNT_BITS'(BASE_FREQ_BITS - 1);
               state_in = PH_FMOD;
            end
         end
         PH_FMOD: begin
            // reduce f0 modulo d, MSB first
            r_in = res;
            if (cnt_ff == '0) begin
               fm_in    = res;
               r_in     = '0;
               cnt_in   = CNT_BITS'(FRAME_BITS - 1);
               state_in = PH_MDBL;
            end else begin
               cnt_in = cnt_ff - CNT_BITS'(1);
            end
         end
         PH_MDBL: begin
            r_in     = res;
            state_in = PH_MADD;
         end
         PH_MADD: begin
            r_in   = res;
            mag_in = {mag_ff[FRAME_BITS-2:0], 1'b0};
            if (cnt_ff == '0) begin
               state_in = PH_NEG;
            end else begin
               cnt_in   = cnt_ff - CNT_BITS'(1);
               state_in = PH_MDBL;
            end
         end
         PH_NEG: begin
            // floor modulo for negative frames
            if (neg_ff && (r_ff != '0)) begin
               r_in = d_ff - r_ff;
            end
            cnt_in   = CNT_BITS'(PHASE_BITS - 1);
            state_in = PH_DIV;
         end
         PH_DIV: begin
            r_in = res;
            q_in = {q_ff[PHASE_BITS-2:0], fits};
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = PH_IDLE;
            end else begin
               cnt_in = cnt_ff - CNT_BITS'(1);
            end
         end
         default: state_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      fm_ff  <= fm_in;
      d_ff   <= d_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      q_ff   <= q_in;
   end

   assign done  = done_ff;
   assign phase = 32'(q_ff) << (32 - PHASE_BITS);

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff != PH_IDLE && state_ff != PH_FMOD) |-> (r_ff < d_ff))
      else $error("remainder not reduced below divisor");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == PH_IDLE))
      else $error("phase unit started while busy");

   a_madd_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == PH_MADD) |=> (state_ff == PH_MDBL || state_ff == PH_NEG))
      else $error("multiply step left its loop");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (state_ff == PH_IDLE))
      else $error("done raised while busy");

endmodule

// ===== tb/bwg_sample_checker.sv =====
// Sample checker for the waveform generator: tracks config, predicts each sample, compares.
module bwg_sample_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic signed [bwg_pkg::FRAME_BITS-1:0]  req_frame_index,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic signed [bwg_pkg::SAMPLE_BITS-1:0] rsp_sample_value,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [bwg_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bwg_pkg::RATE_BITS-1:0]         csr_data,
   output int                                    fail_count,
   output int                                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import bwg_pkg::*;

   localparam int unsigned SINE_DEPTH    = DEFAULT_SINE_TABLE_DEPTH;
   localparam int unsigned SINE_IDX_BITS = $clog2(SINE_DEPTH);
   localparam int unsigned PHASE_WIDTH   = DEFAULT_PHASE_BITS;

   logic [15:0]           quarter_sine [SINE_DEPTH];
   logic [RATE_BITS-1:0]  sample_rate_reg;
   logic [SHAPE_BITS-1:0] wave_shape_reg;
   logic [31:0]           noise_lfsr;
   logic signed [15:0]    expected_samples [$];
   logic signed [15:0]    expected_value;
   int                    errors = 0;

   // Q30 Taylor series of sin, rounded half up to Q15
   function automatic logic [15:0] taylor_quarter_sine(input int unsigned i);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      acc;
      x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
         term = (term * x2) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      acc = (acc + 16384) >>> 15;
      if (acc > 32767) begin
         acc = 32767;
      end
      return acc[15:0];
   endfunction

   initial begin
      for (int i = 0; i < SINE_DEPTH; i++) begin
         quarter_sine[i] = taylor_quarter_sine(i);
      end
   end

   // Floor-mod fraction of frame * f0 / rate, PHASE_WIDTH bits left-aligned in 32
   function automatic logic [31:0] frame_phase(input logic [31:0]          frame,
                                               input logic [RATE_BITS-1:0] rate);
      logic [31:0] abs_frame;
      logic [63:0] divisor;
      logic [63:0] rem;
      logic [63:0] quo;
      divisor   = {30'd0, ((rate == '0) ? 18'd1 : rate), 16'd0};
      abs_frame = frame[31] ? (~frame + 32'd1) : frame;
      rem       = ({32'd0, abs_frame} * 64'(BASE_FREQ_Q16)) % divisor;
      if (frame[31] && rem != 0) begin
         rem = divisor - rem;
      end
      quo = '0;
      for (int b = 0; b < PHASE_WIDTH; b++) begin
         rem = rem << 1;
         quo = quo << 1;
         if (rem >= divisor) begin
            rem    = rem - divisor;
            quo[0] = 1'b1;
         end
      end
      quo = quo << (32 - PHASE_WIDTH);
      return quo[31:0];
   endfunction

   // Predicts the sample for a frame; advances the noise LFSR only on noise samples
   function automatic logic [15:0] predict_sample(input logic [31:0] frame);
      logic [31:0]              t;
      logic [SINE_IDX_BITS-1:0] idx;
      logic [15:0]              mag;
      int                       tri_level;
      t = frame_phase(frame, sample_rate_reg);
      case (wave_shape_reg)
         SHAPE_SINE: begin
            idx = t[29 -: SINE_IDX_BITS];
            if (t[30]) begin
               mag = (idx == '0) ? 16'd32767 : quarter_sine[SINE_DEPTH - idx];
            end else begin
               mag = quarter_sine[idx];
            end
            return t[31] ? -mag : mag;
         end
         SHAPE_SAW: begin
            return {~t[31], t[30:16]};
         end
         SHAPE_SQUARE: begin
            return (t > 32'h8000_0000) ? 16'h7FFF : 16'h8000;
         end
         SHAPE_TRIANGLE: begin
            if (!t[31]) begin
               tri_level = int'(t >> 15) - 32768;
            end else begin
               tri_level = 32768 - int'((t - 32'h8000_0000) >> 15);
               if (tri_level > 32767) begin
                  tri_level = 32767;
               end
            end
            return tri_level[15:0];
         end
         SHAPE_NOISE: begin
            noise_lfsr = noise_lfsr[0] ? ((noise_lfsr >> 1) ^ LFSR_TAPS) : (noise_lfsr >> 1);
            return noise_lfsr[31:16];
         end
         default: begin
            return 16'd0;
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_samples.delete();
         sample_rate_reg = RATE_RESET;
         wave_shape_reg  = SHAPE_RESET;
         noise_lfsr      = LFSR_SEED;
      end else begin
         // compare before queuing so a same-edge request never matches its own result
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               $error("sample_value %0d transferred with no item outstanding",
                      rsp_sample_value);
               errors++;
            end else begin
               expected_value = expected_samples.pop_front();
               if (rsp_sample_value !== expected_value) begin
                  $error("sample_value mismatch: expected %0d, actual %0d",
                         expected_value, rsp_sample_value);
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SAMPLE_RATE) begin
               sample_rate_reg = csr_data;
            end else if (csr_index == CSR_WAVE_SHAPE) begin
               wave_shape_reg = csr_data[SHAPE_BITS-1:0];
            end
         end
         if (req_valid && req_ready) begin
            expected_samples.push_back(predict_sample(req_frame_index));
         end
      end
      outstanding <= expected_samples.size();
      fail_count  <= errors;
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the waveform generator testbench: clock, reset, stimulus, receiver stalls, verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bwg_pkg::*;

   localparam int CLOCK_PERIOD    = 4;
   localparam int RESET_CYCLES    = 10;
   localparam int RANDOM_PHASES   = 16;
   localparam int ITEMS_PER_PHASE = 53;
   localparam int HOLD_CYCLES     = 600;
   localparam int TAIL_CYCLES     = 150;
   localparam int WATCHDOG_LIMIT  = 5000;

   logic                          clock           = 1'b0;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic                          req_ready;
   logic signed [FRAME_BITS-1:0]  req_frame_index = '0;
   logic                          rsp_valid;
   logic                          rsp_ready       = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_value;
   logic                          csr_valid       = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index       = '0;
   logic [RATE_BITS-1:0]          csr_data        = '0;
   int                            fail_count;
   int                            outstanding;

   int   req_idle_pct  = 0;
   int   rsp_stall_pct = 0;
   int   hold_requests = 0;
   int   holds_served  = 0;
   int   hold_left     = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   basic_waveform_generator_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_frame_index  (req_frame_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_value (rsp_sample_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   bwg_sample_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_frame_index  (req_frame_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_value (rsp_sample_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   // Receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (holds_served != hold_requests) begin
         hold_left    = HOLD_CYCLES;
         holds_served = hold_requests;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_frame(input logic [FRAME_BITS-1:0] frame);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_frame_index <= frame;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every sample has come back
   task automatic drain_samples();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [RATE_BITS-1:0]      data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [FRAME_BITS-1:0] random_frame();
      logic [FRAME_BITS-1:0] small_mag;
      small_mag = $urandom_range(1 << 20);
      case ($urandom_range(3))
         0:       return small_mag;
         1:       return -small_mag;
         default: return $urandom();
      endcase
   endfunction

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      logic [RATE_BITS-1:0]  rate;
      logic [SHAPE_BITS-1:0] shape;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner frames at the reset configuration
      send_frame(32'sd0);
      send_frame(32'sd1);
      send_frame(-32'sd1);
      send_frame(32'h7FFF_FFFF);
      send_frame(32'h8000_0000);
      drain_samples();

      // zero rate acts as one: frames 16384/32768/49152 land on exact quarter phases
      write_csr(CSR_SAMPLE_RATE, '0);
      for (int s = 0; s < 8; s++) begin
         write_csr(CSR_WAVE_SHAPE, RATE_BITS'(s));
         send_frame(32'sd16384);
         if (s < 5) begin
            send_frame(32'sd32768);
            send_frame(32'sd49152);
         end
         drain_samples();
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 4)
            0:       begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin req_idle_pct = 48; rsp_stall_pct = 0;  end
            2:       begin req_idle_pct = 0;  rsp_stall_pct = 48; end
            default: begin req_idle_pct = 19; rsp_stall_pct = 19; end
         endcase
         case (p % 8)
            0:       rate = 18'd1000;
            1:       rate = 18'd192000;
            2:       rate = 18'd44100;
            3:       rate = RATE_BITS'($urandom_range(192000, 1000));
            4:       rate = 18'd1;
            5:       rate = '1;
            6:       rate = RATE_BITS'($urandom_range(262143));
            default: rate = 18'd48000;
         endcase
         shape = (p < 12) ? SHAPE_BITS'(p % 6) : SHAPE_BITS'($urandom_range(7));
         write_csr(CSR_SAMPLE_RATE, rate);
         write_csr(CSR_WAVE_SHAPE, {15'($urandom()), shape});
         // hold the receiver off so the block fills and stalls its input
         if (p % 8 == 2) begin
            hold_requests++;
         end
         repeat (ITEMS_PER_PHASE) send_frame(random_frame());
         drain_samples();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
